[design/hslc_pkg.sv]
// Shared types and constants for the HSL colorize pixel pipeline.
`default_nettype none

package hslc_pkg;

    // Source pixel as it arrives on the input channel.
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_pixel;

    // Colorized pixel as it leaves on the output channel.
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out_pixel;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        CFG_TARGET_HUE   = 2'd0,
        CFG_TARGET_SAT   = 2'd1,
        CFG_BLEND_WEIGHT = 2'd2,
        CFG_FULL_REPLACE = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    // A blend weight of this value selects the colorized pixel alone.
    localparam logic [8:0] BLEND_FULL = 9'd256;

    // Hue offsets of the three channels, in multiples of 120 degrees.
    localparam int HUE_OFS_RED   = 1;
    localparam int HUE_OFS_GREEN = 0;
    localparam int HUE_OFS_BLUE  = -1;

    // Blend controls that the output stage needs from the register file.
    typedef struct packed {
        logic       sat_zero;
        logic       full_replace;
        logic [8:0] weight;
    } t_blend_cfg;

endpackage

`default_nettype wire

[design/hslc_frac_rom.sv]
// Constant table of (index * SCALE << FRAC_BITS) / 255 for an 8-bit index.
`default_nettype none

module hslc_frac_rom #(
    parameter int FRAC_BITS = 16,
    parameter int SCALE     = 1,
    localparam int OUT_W    = FRAC_BITS + $clog2(SCALE + 1)
) (
    input  wire logic [7:0]       i_index,
    output logic      [OUT_W-1:0] o_value
);

    logic [OUT_W-1:0] w_tab [256];

    for (genvar gi = 0; gi < 256; gi++) begin : g_ent
        localparam logic [63:0] VAL = ((64'(gi) * 64'(SCALE)) << FRAC_BITS) / 64'd255;
        assign w_tab[gi] = VAL[OUT_W-1:0];
    end

    assign o_value = w_tab[i_index];

endmodule

`default_nettype wire

[design/hslc_hue_chan.sv]
// One color channel: hue-to-RGB ramp and conversion to a byte, four stages.
`default_nettype none

module hslc_hue_chan #(
    parameter int FRAC_BITS = 16,
    parameter int HUE_OFS   = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_adv,
    input  wire logic [FRAC_BITS+8:0]   i_hue_fix,
    input  wire logic [FRAC_BITS:0]     i_m1,
    input  wire logic [FRAC_BITS:0]     i_m2,
    input  wire logic [FRAC_BITS:0]     i_d,
    output logic      [7:0]             o_byte
);

    import hslc_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int X_W  = F + 9;
    localparam int H_W  = F + 10;
    localparam int XR_W = F + 6;
    localparam int P_W  = 2 * F + 7;
    localparam int U_W  = F + 4;
    localparam int Q_W  = 2 * F + 5;
    localparam int R_W  = F + 5;
    localparam int V_W  = F + 2;
    localparam int B_W  = F + 10;

    localparam logic [X_W-1:0] DEG60  = X_W'(longint'(60) << F);
    localparam logic [X_W-1:0] DEG180 = X_W'(longint'(180) << F);
    localparam logic [X_W-1:0] DEG240 = X_W'(longint'(240) << F);
    localparam logic [X_W-1:0] DEG360 = X_W'(longint'(360) << F);
    localparam longint OFS_L = longint'(HUE_OFS) * (longint'(120) << F);
    localparam logic signed [H_W-1:0] OFS_FIX = H_W'(OFS_L);
    // Reciprocal of 15 scaled by 2^(F+4); the estimate is off by at most one.
    localparam logic [F:0] RECIP = (F+1)'((longint'(1) << (F + 4)) / 15);

    typedef enum logic [1:0] {
        REG_RISE,
        REG_HIGH,
        REG_FALL,
        REG_LOW
    } t_region;

    // Hue setup follows the configuration every cycle.
    logic signed [H_W-1:0] w_xs;
    logic signed [H_W-1:0] w_xf;
    logic [X_W-1:0]        w_x;
    logic [X_W-1:0]        w_fall;
    t_region               n_region;
    logic [XR_W-1:0]       n_xr;
    t_region               r_region;
    logic [XR_W-1:0]       r_xr;

    always_comb begin
        w_xs = $signed({1'b0, i_hue_fix}) + OFS_FIX;
        if (w_xs > $signed({1'b0, DEG360})) begin
            w_xf = w_xs - $signed({1'b0, DEG360});
        end else if (w_xs < $signed({H_W{1'b0}})) begin
            w_xf = w_xs + $signed({1'b0, DEG360});
        end else begin
            w_xf = w_xs;
        end
        w_x    = w_xf[X_W-1:0];
        w_fall = DEG240 - w_x;
        if (w_x < DEG60) begin
            n_region = REG_RISE;
            n_xr     = w_x[XR_W-1:0];
        end else if (w_x < DEG180) begin
            n_region = REG_HIGH;
            n_xr     = '0;
        end else if (w_x < DEG240) begin
            n_region = REG_FALL;
            n_xr     = w_fall[XR_W-1:0];
        end else begin
            n_region = REG_LOW;
            n_xr     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_region <= n_region;
        r_xr     <= n_xr;
    end

    // Stage a: ramp product.
    logic [P_W-1:0] r_prod;
    logic [F:0]     r_m1a;
    logic [F:0]     r_m2a;
    // Stage b: divide by 60 as a shift by two and a reciprocal multiply by 1/15.
    logic [U_W-1:0] w_u;
    logic [Q_W-1:0] r_qm;
    logic [U_W-1:0] r_u;
    logic [F:0]     r_m1b;
    logic [F:0]     r_m2b;
    // Stage c: quotient correction and channel value.
    logic [F:0]     w_qe;
    logic [R_W-1:0] w_q15;
    logic [R_W-1:0] w_rem;
    logic [F:0]     w_q;
    logic [V_W-1:0] n_v;
    logic [V_W-1:0] r_v;
    // Stage d: scale to a byte.
    logic [B_W-1:0] w_scaled;
    logic [B_W-1:0] w_p;

    assign w_u   = r_prod[F+2 +: U_W];
    assign w_qe  = r_qm[F+4 +: F+1];
    assign w_q15 = (R_W'(w_qe) << 4) - R_W'(w_qe);
    assign w_rem = R_W'(r_u) - w_q15;
    assign w_q   = (w_rem >= R_W'(15)) ? w_qe + (F+1)'(1) : w_qe;

    always_comb begin
        case (r_region)
            REG_RISE: n_v = V_W'(r_m1b) + V_W'(w_q);
            REG_FALL: n_v = V_W'(r_m1b) + V_W'(w_q);
            REG_HIGH: n_v = V_W'(r_m2b);
            REG_LOW:  n_v = V_W'(r_m1b);
            default:  n_v = V_W'(r_m1b);
        endcase
    end

    assign w_scaled = (B_W'(r_v) << 8) - B_W'(r_v);
    assign w_p      = w_scaled >> F;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= P_W'(i_d) * P_W'(r_xr);
            r_m1a  <= i_m1;
            r_m2a  <= i_m2;
            r_qm   <= Q_W'(w_u) * Q_W'(RECIP);
            r_u    <= w_u;
            r_m1b  <= r_m1a;
            r_m2b  <= r_m2a;
            r_v    <= n_v;
            o_byte <= (w_p > B_W'(255)) ? 8'hFF : w_p[7:0];
        end
    end

endmodule

`default_nettype wire

[design/hslc_pipe.sv]
// Pixel datapath: lightness, HSL to RGB over three channels, and blending.
`default_nettype none

module hslc_pipe #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [FRAC_BITS+8:0]   i_hue_fix,
    input  wire logic [FRAC_BITS:0]     i_sat_fix,
    input  wire hslc_pkg::t_blend_cfg   i_blend,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire hslc_pkg::t_in_pixel    i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output hslc_pkg::t_out_pixel        o_out_data
);

    import hslc_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int NUM_ST = 10;
    localparam int LAST   = NUM_ST - 1;
    localparam logic [F:0] HALF = (F+1)'(1) << (F - 1);

    logic              w_adv;
    logic [NUM_ST-1:0] r_vld;

    // Whole pipeline moves together unless the output beat is held.
    assign w_adv       = !r_vld[LAST] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NUM_ST-2:0], i_in_valid};
        end
    end

    // Source pixel and lightness ride along for the blend and gray cases.
    t_in_pixel  r_px  [LAST];
    logic [7:0] r_lum [1:LAST-1];

    logic [7:0] w_mx;
    logic [7:0] w_mn;
    logic [7:0] n_lum;

    always_comb begin
        w_mx = r_px[0].in_red;
        w_mn = r_px[0].in_red;
        if (r_px[0].in_green > w_mx) begin
            w_mx = r_px[0].in_green;
        end
        if (r_px[0].in_blue > w_mx) begin
            w_mx = r_px[0].in_blue;
        end
        if (r_px[0].in_green < w_mn) begin
            w_mn = r_px[0].in_green;
        end
        if (r_px[0].in_blue < w_mn) begin
            w_mn = r_px[0].in_blue;
        end
    end

    // ((max + min) * 255 + 255) / 510 reduces to (max + min + 1) / 2.
    assign n_lum = 8'(({1'b0, w_mx} + {1'b0, w_mn} + 9'd1) >> 1);

    logic [F:0]       w_l;
    logic [F:0]       r_l;
    logic [F:0]       r_l3;
    logic [2*F+1:0]   w_ls_prod;
    logic [F:0]       r_ls;
    logic [F+1:0]     n_m1;
    logic [F+1:0]     n_m2;
    logic [F+1:0]     n_d;
    logic [F:0]       r_m1;
    logic [F:0]       r_m2;
    logic [F:0]       r_d;

    hslc_frac_rom #(
        .FRAC_BITS (FRAC_BITS),
        .SCALE     (1)
    ) u_lum_rom (
        .i_index (r_lum[1]),
        .o_value (w_l)
    );

    assign w_ls_prod = (2*F+2)'(r_l) * (2*F+2)'(i_sat_fix);

    always_comb begin
        if (r_l3 <= HALF) begin
            n_m2 = (F+2)'(r_l3) + (F+2)'(r_ls);
            n_m1 = (F+2)'(r_l3) - (F+2)'(r_ls);
            n_d  = (F+2)'(r_ls) << 1;
        end else begin
            n_m2 = (F+2)'(r_l3) + (F+2)'(i_sat_fix) - (F+2)'(r_ls);
            n_m1 = (F+2)'(r_l3) + (F+2)'(r_ls) - (F+2)'(i_sat_fix);
            n_d  = ((F+2)'(i_sat_fix) - (F+2)'(r_ls)) << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px[0] <= i_in_data;
            for (int k = 1; k < LAST; k++) begin
                r_px[k] <= r_px[k-1];
            end
            r_lum[1] <= n_lum;
            for (int k = 2; k < LAST; k++) begin
                r_lum[k] <= r_lum[k-1];
            end
            r_l  <= w_l;
            r_ls <= w_ls_prod[F +: F+1];
            r_l3 <= r_l;
            r_m1 <= n_m1[F:0];
            r_m2 <= n_m2[F:0];
            r_d  <= n_d[F:0];
        end
    end

    logic [7:0] w_new_red;
    logic [7:0] w_new_green;
    logic [7:0] w_new_blue;

    hslc_hue_chan #(
        .FRAC_BITS (FRAC_BITS),
        .HUE_OFS   (HUE_OFS_RED)
    ) u_chan_red (
        .i_clk     (i_clk),
        .i_adv     (w_adv),
        .i_hue_fix (i_hue_fix),
        .i_m1      (r_m1),
        .i_m2      (r_m2),
        .i_d       (r_d),
        .o_byte    (w_new_red)
    );

    hslc_hue_chan #(
        .FRAC_BITS (FRAC_BITS),
        .HUE_OFS   (HUE_OFS_GREEN)
    ) u_chan_green (
        .i_clk     (i_clk),
        .i_adv     (w_adv),
        .i_hue_fix (i_hue_fix),
        .i_m1      (r_m1),
        .i_m2      (r_m2),
        .i_d       (r_d),
        .o_byte    (w_new_green)
    );

    hslc_hue_chan #(
        .FRAC_BITS (FRAC_BITS),
        .HUE_OFS   (HUE_OFS_BLUE)
    ) u_chan_blue (
        .i_clk     (i_clk),
        .i_adv     (w_adv),
        .i_hue_fix (i_hue_fix),
        .i_m1      (r_m1),
        .i_m2      (r_m2),
        .i_d       (r_d),
        .o_byte    (w_new_blue)
    );

    function automatic logic [7:0] blend_byte(
        input logic [7:0] new_val,
        input logic [7:0] old_val,
        input logic [7:0] gray,
        input t_blend_cfg cfg
    );
        logic [7:0]  pick;
        logic [16:0] sum;
        pick = cfg.sat_zero ? gray : new_val;
        sum  = 17'(pick) * 17'(cfg.weight) + 17'(old_val) * 17'(BLEND_FULL - cfg.weight);
        return cfg.full_replace ? pick : sum[15:8];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out_data.out_red   <= blend_byte(w_new_red, r_px[LAST-1].in_red,
                                               r_lum[LAST-1], i_blend);
            o_out_data.out_green <= blend_byte(w_new_green, r_px[LAST-1].in_green,
                                               r_lum[LAST-1], i_blend);
            o_out_data.out_blue  <= blend_byte(w_new_blue, r_px[LAST-1].in_blue,
                                               r_lum[LAST-1], i_blend);
        end
    end

    // A held output freezes every stage.
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    // An accepted beat lands in the input stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted beat missing from the input stage");

    // A beat in the middle stage moves on when the pipeline advances.
    a_mid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[4]) |=> r_vld[5])
        else $error("beat lost between stages");

endmodule

`default_nettype wire

[design/hsl_colorize_pixel.sv]
// Top level of the HSL colorize pixel block: register file and pixel pipeline.
//
//  Channel   Direction  Handshake                 Payload
//  in        sink       i_in_valid / o_in_ready   i_in_data   (red, green, blue)
//  out       source     o_out_valid / i_out_ready o_out_data  (red, green, blue)
//  cfg       sink       i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// One pixel beat is taken every cycle while the output is not held; each beat
// passes through the ten register stages of the pipeline (the two
// multiplies of the hue ramp and the final scale take one stage each).
// Reset is synchronous and active low; it clears the valid bits and loads the
// register defaults (hue 0, saturation 0, weight 256, full replace on).
// When the output beat is held, the whole pipeline holds and o_in_ready drops;
// no beat is lost or repeated.
`default_nettype none

module hsl_colorize_pixel #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [hslc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hslc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire hslc_pkg::t_in_pixel            i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output hslc_pkg::t_out_pixel                o_out_data
);

    import hslc_pkg::*;

    localparam int F = FRAC_BITS;

    logic [7:0] r_target_hue;
    logic [7:0] r_target_saturation;
    logic [8:0] r_blend_weight;
    logic       r_full_replace;

    // Register file. Every two-bit index names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_hue        <= 8'd0;
            r_target_saturation <= 8'd0;
            r_blend_weight      <= BLEND_FULL;
            r_full_replace      <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_HUE:   r_target_hue        <= i_cfg_data[7:0];
                CFG_TARGET_SAT:   r_target_saturation <= i_cfg_data[7:0];
                CFG_BLEND_WEIGHT: r_blend_weight      <= i_cfg_data[8:0];
                CFG_FULL_REPLACE: r_full_replace      <= i_cfg_data[0];
                default:          r_full_replace      <= r_full_replace;
            endcase
        end
    end

    // Hue in degrees and saturation in fixed point come from constant tables
    // and are registered, since they only change with the configuration.
    logic [F+8:0] w_hue_fix;
    logic [F:0]   w_sat_fix;
    logic [F+8:0] r_hue_fix;
    logic [F:0]   r_sat_fix;

    hslc_frac_rom #(
        .FRAC_BITS (FRAC_BITS),
        .SCALE     (360)
    ) u_hue_rom (
        .i_index (r_target_hue),
        .o_value (w_hue_fix)
    );

    hslc_frac_rom #(
        .FRAC_BITS (FRAC_BITS),
        .SCALE     (1)
    ) u_sat_rom (
        .i_index (r_target_saturation),
        .o_value (w_sat_fix)
    );

    always_ff @(posedge i_clk) begin
        r_hue_fix <= w_hue_fix;
        r_sat_fix <= w_sat_fix;
    end

    // Weights above 256 act as 256. Zero saturation gives plain gray.
    t_blend_cfg w_blend;

    always_comb begin
        w_blend.sat_zero     = (r_target_saturation == 8'd0);
        w_blend.full_replace = r_full_replace;
        w_blend.weight       = (r_blend_weight > BLEND_FULL) ? BLEND_FULL : r_blend_weight;
    end

    hslc_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hue_fix   (r_hue_fix),
        .i_sat_fix   (r_sat_fix),
        .i_blend     (w_blend),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[tb/hsl_colorize_pixel_test.sv]
// Self-checking testbench for the HSL colorize pixel pipeline.

module hsl_colorize_pixel_test;

    import hslc_pkg::*;

    // The block is built with its default fraction width; the predictor uses the same.
    localparam int     FRAC    = 16;
    localparam longint DEG60   = longint'(60) << FRAC;
    localparam longint DEG120  = longint'(120) << FRAC;
    localparam longint DEG180  = longint'(180) << FRAC;
    localparam longint DEG240  = longint'(240) << FRAC;
    localparam longint DEG360  = longint'(360) << FRAC;
    localparam longint HALF    = longint'(1) << (FRAC - 1);

    // Chance, in percent, that either side idles in a given cycle.
    localparam int unsigned IDLE_PCT = 28;

    // Cycles to wait after the last result for any stray beat; the pipeline is ten deep.
    localparam int unsigned TAIL_CYCLES = 24;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_pixel             i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_pixel            o_out_data;

    // Shadow copy of the register file, updated at the edge where the block takes a write.
    logic [7:0] hue_reg;
    logic [7:0] sat_reg;
    logic [8:0] weight_reg;
    logic       replace_reg;

    // Colorized pixels that the block still owes us, oldest first.
    t_out_pixel pending_colors[$];

    int unsigned error_count;
    int unsigned checked_beats;

    // When set, the sender leaves gaps and the receiver stalls at random.
    bit          idle_en;
    // Number of cycles the receiver must still hold off; counted down by the receiver.
    int unsigned ready_hold;

    hsl_colorize_pixel DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("** hsl_colorize_pixel: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Piecewise-linear hue ramp. The hue position is folded into range once;
    // a position of exactly 360 degrees is left alone and lands on m1.
    function automatic longint hue_ramp(input longint m1, input longint m2,
                                        input longint hue_pos);
        longint x;
        longint span;
        x = hue_pos;
        if (x > DEG360)
            x = x - DEG360;
        else if (x < 0)
            x = x + DEG360;
        span = (m2 > m1) ? m2 - m1 : longint'(0);
        if (x < DEG60)
            return m1 + ((span * x) >> FRAC) / 60;
        if (x < DEG180)
            return m2;
        if (x < DEG240)
            return m1 + ((span * (DEG240 - x)) >> FRAC) / 60;
        return m1;
    endfunction

    // Scale a Q.FRAC value in 0..1 to a byte, truncating and clamping.
    function automatic logic [7:0] scale_to_byte(input longint v);
        longint p;
        if (v <= 0)
            return 8'd0;
        p = (v * 255) >> FRAC;
        return (p > 255) ? 8'd255 : 8'(p);
    endfunction

    // Expected colorized pixel for one source pixel under the current registers.
    function automatic t_out_pixel colorize_model(input t_in_pixel px);
        int unsigned src [3];
        int unsigned chan [3];
        int unsigned hi;
        int unsigned lo;
        int unsigned lum;
        int unsigned w;
        longint      h;
        longint      s;
        longint      l;
        longint      ls;
        longint      m1;
        longint      m2;
        t_out_pixel  res;
        src[0] = px.in_red;
        src[1] = px.in_green;
        src[2] = px.in_blue;
        hi = src[0];
        lo = src[0];
        for (int i = 1; i < 3; i++) begin
            if (src[i] > hi) hi = src[i];
            if (src[i] < lo) lo = src[i];
        end
        lum = ((hi + lo) * 255 + 255) / 510;

        if (sat_reg == 8'd0) begin
            // Without saturation every channel is the lightness itself.
            for (int i = 0; i < 3; i++) chan[i] = lum;
        end else begin
            h  = ((longint'(hue_reg) * 360) << FRAC) / 255;
            s  = (longint'(sat_reg) << FRAC) / 255;
            l  = (longint'(lum) << FRAC) / 255;
            ls = (l * s) >> FRAC;
            if (l <= HALF)
                m2 = l + ls;
            else
                m2 = l + s - ls;
            m1 = 2 * l - m2;
            chan[0] = scale_to_byte(hue_ramp(m1, m2, h + DEG120));
            chan[1] = scale_to_byte(hue_ramp(m1, m2, h));
            chan[2] = scale_to_byte(hue_ramp(m1, m2, h - DEG120));
        end

        if (!replace_reg) begin
            // Weights past 256 behave as 256.
            w = (weight_reg > 9'd256) ? 256 : weight_reg;
            for (int i = 0; i < 3; i++)
                chan[i] = (chan[i] * w + src[i] * (256 - w)) >> 8;
        end

        res.out_red   = 8'(chan[0]);
        res.out_green = 8'(chan[1]);
        res.out_blue  = 8'(chan[2]);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH beat %0d %s: got %0d, expected %0d",
                     checked_beats, what, got, want);
    endtask

    // Every output beat is compared with the oldest pixel still owed.
    always @(posedge i_clk) begin
        t_out_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_colors.size() == 0) begin
                report_mismatch("unexpected beat, red", o_out_data.out_red, 0);
            end else begin
                want = pending_colors.pop_front();
                if (o_out_data.out_red !== want.out_red)
                    report_mismatch("red", o_out_data.out_red, want.out_red);
                if (o_out_data.out_green !== want.out_green)
                    report_mismatch("green", o_out_data.out_green, want.out_green);
                if (o_out_data.out_blue !== want.out_blue)
                    report_mismatch("blue", o_out_data.out_blue, want.out_blue);
            end
            checked_beats++;
        end
    end

    // Receiver: decides ready for the coming edge at each falling edge. A pending
    // hold-off wins over the random stalls.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; all of them start and end at a falling edge.
    // ------------------------------------------------------------------

    // Offer one pixel beat and return once it is taken. Valid is left high so a
    // following beat can go out back to back; end_burst lowers it.
    task automatic send_pixel(input t_in_pixel px);
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        pending_colors.push_back(colorize_model(px));
        @(negedge i_clk);
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_in_pixel px;
        px.in_red   = r;
        px.in_green = g;
        px.in_blue  = b;
        send_pixel(px);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Every pixel has a result, so once nothing is owed the pipeline is empty.
    task automatic wait_drained();
        end_burst();
        while (pending_colors.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [8:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_TARGET_HUE:   hue_reg     = value[7:0];
            CFG_TARGET_SAT:   sat_reg     = value[7:0];
            CFG_BLEND_WEIGHT: weight_reg  = value;
            CFG_FULL_REPLACE: replace_reg = value[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Writes the whole register file; only called with the pipeline empty.
    task automatic apply_settings(input logic [7:0] hue, input logic [7:0] sat,
                                  input logic [8:0] weight, input logic replace);
        write_register(CFG_TARGET_HUE, {1'b0, hue});
        write_register(CFG_TARGET_SAT, {1'b0, sat});
        write_register(CFG_BLEND_WEIGHT, weight);
        write_register(CFG_FULL_REPLACE, {8'd0, replace});
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly uniform pixels, with grays and all-extreme channels mixed in.
    function automatic t_in_pixel random_pixel();
        t_in_pixel px;
        int unsigned kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
            px.in_red   = 8'($urandom_range(255));
            px.in_green = px.in_red;
            px.in_blue  = px.in_red;
        end else if (kind == 1) begin
            px.in_red   = $urandom_range(1) ? 8'd255 : 8'd0;
            px.in_green = $urandom_range(1) ? 8'd255 : 8'd0;
            px.in_blue  = $urandom_range(1) ? 8'd255 : 8'd0;
        end else begin
            px = t_in_pixel'($urandom_range(24'hFF_FFFF));
        end
        return px;
    endfunction

    task automatic send_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) send_pixel(random_pixel());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: zero saturation with full replace gives a gray of the lightness.
    task automatic test_reset_defaults();
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd200, 8'd57);
        wait_drained();
    endtask

    // Full saturation at the unfolded 360 degree hue with lightness on either side
    // of one half, then the lowest saturation at hue 0 and a 120 degree hue setting.
    task automatic test_hue_extremes();
        apply_settings(8'd255, 8'd255, BLEND_FULL, 1'b1);
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd127, 8'd127, 8'd127);
        send_rgb(8'd128, 8'd128, 8'd128);
        send_rgb(8'd255, 8'd255, 8'd255);
        wait_drained();
        apply_settings(8'd0, 8'd1, BLEND_FULL, 1'b1);
        send_rgb(8'd10, 8'd240, 8'd90);
        send_rgb(8'd255, 8'd0, 8'd255);
        wait_drained();
        apply_settings(8'd85, 8'd200, BLEND_FULL, 1'b1);
        send_rgb(8'd60, 8'd120, 8'd180);
        send_rgb(8'd200, 8'd30, 8'd90);
        wait_drained();
    endtask

    // Blending: zero weight passes the source, mid weight mixes, and an
    // oversized weight saturates to the colorized pixel, also for zero saturation.
    task automatic test_blend();
        apply_settings(8'd170, 8'd255, 9'd0, 1'b0);
        send_rgb(8'd12, 8'd250, 8'd99);
        wait_drained();
        apply_settings(8'd170, 8'd255, 9'd511, 1'b0);
        send_rgb(8'd12, 8'd250, 8'd99);
        wait_drained();
        apply_settings(8'd40, 8'd128, 9'd128, 1'b0);
        send_rgb(8'd255, 8'd128, 8'd0);
        send_rgb(8'd1, 8'd2, 8'd254);
        wait_drained();
        apply_settings(8'd40, 8'd0, 9'd300, 1'b0);
        send_rgb(8'd255, 8'd128, 8'd0);
        wait_drained();
    endtask

    // Random pixels over a series of register settings, the extremes first.
    task automatic test_random_settings();
        apply_settings(8'd0, 8'd255, BLEND_FULL, 1'b1);
        send_random(70);
        wait_drained();
        apply_settings(8'd255, 8'd255, 9'd0, 1'b0);
        send_random(70);
        wait_drained();
        apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 9'd511, 1'b0);
        send_random(70);
        wait_drained();
        apply_settings(8'($urandom_range(255)), 8'd0, 9'($urandom_range(256)), 1'b0);
        send_random(70);
        wait_drained();
        for (int phase = 0; phase < 3; phase++) begin
            apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                           9'($urandom_range(511)), 1'($urandom_range(1)));
            send_random(70);
            wait_drained();
        end
    endtask

    // The receiver holds off long enough for the pipeline to fill and stop
    // taking input while the sender keeps offering beats.
    task automatic test_output_stall();
        apply_settings(8'($urandom_range(255)), 8'($urandom_range(1, 255)),
                       9'($urandom_range(256)), 1'b0);
        ready_hold = 80;
        send_random(60);
        wait_drained();
    endtask

    // A stretch with neither side idling: one beat per cycle both ways.
    task automatic test_full_rate();
        apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                       BLEND_FULL, 1'b1);
        idle_en = 1'b0;
        send_random(100);
        wait_drained();
        idle_en = 1'b1;
    endtask

    // The sender stops until everything owed has come out, then resumes with
    // the same settings.
    task automatic test_drain_pause();
        apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                       9'($urandom_range(511)), 1'b0);
        send_random(30);
        wait_drained();
        send_random(30);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_TARGET_HUE;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        hue_reg     = 8'd0;
        sat_reg     = 8'd0;
        weight_reg  = BLEND_FULL;
        replace_reg = 1'b1;
        error_count   = 0;
        checked_beats = 0;
        idle_en     = 1'b1;
        ready_hold  = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_hue_extremes();
        test_blend();
        test_random_settings();
        test_output_stall();
        test_full_rate();
        test_drain_pause();

        // Give any stray beat time to show up before the verdict.
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0 && pending_colors.size() == 0) begin
            $display("** hsl_colorize_pixel: PASSED **");
        end else begin
            $display("** hsl_colorize_pixel: FAILED **");
        end
        $finish;
    end

endmodule
